### design/smmat_pkg.sv
// ----------------------------------------------------------------------------
// smmat_pkg: shared types and constants for the sample statistics tracker
// Beat payloads, command codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package smmat_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 22;
    localparam int SUM_BITS    = 32;

    // Minimum reported while no sample has been taken since clear
    localparam int MIN_EMPTY_RAW = 1000;
    localparam logic [SAMPLE_BITS-1:0] MIN_EMPTY =
        (MIN_EMPTY_RAW > (2 ** SAMPLE_BITS) - 1) ? {SAMPLE_BITS{1'b1}}
                                                 : SAMPLE_BITS'(MIN_EMPTY_RAW);

    // Command codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_HOLD   = 2'd1,
        MODE_RESUME = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // Input beat
    typedef struct packed {
        mode_t                  mode;
        logic [SAMPLE_BITS-1:0] sample;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] last_sample;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic [SAMPLE_BITS-1:0] average;
        logic [COUNT_BITS-1:0]  sample_count;
        logic                   holding;
    } out_beat_t;

    // Running statistics held by the stats block
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] latest;
        logic [SAMPLE_BITS-1:0] min_value;
        logic [SAMPLE_BITS-1:0] max_value;
        logic [SUM_BITS-1:0]    sum;
        logic [COUNT_BITS-1:0]  count;
        logic                   hold;
    } stats_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

### design/smmat_stats.sv
// ----------------------------------------------------------------------------
// smmat_stats: running statistics registers
// Applies one command or sample to min, max, sum, count, last sample and hold.
// ----------------------------------------------------------------------------
module smmat_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  smmat_pkg::in_beat_t beat,
    output smmat_pkg::stats_t   stats
);

    smmat_pkg::stats_t stats_reg;
    smmat_pkg::stats_t stats_next;

    // Update from the accepted beat
    always_comb
    begin
        logic [smmat_pkg::SUM_BITS:0] sum_wide;
        sum_wide   = {1'b0, stats_reg.sum}
                   + (smmat_pkg::SUM_BITS + 1)'(beat.sample);
        stats_next = stats_reg;
        if (update)
        begin
            unique case (beat.mode)
                smmat_pkg::MODE_SAMPLE:
                begin
                    if (!stats_reg.hold)
                    begin
                        stats_next.latest = beat.sample;
                        if (beat.sample < stats_reg.min_value)
                            stats_next.min_value = beat.sample;
                        if (beat.sample > stats_reg.max_value)
                            stats_next.max_value = beat.sample;
                        // count and sum freeze once the count is full
                        if (stats_reg.count != {smmat_pkg::COUNT_BITS{1'b1}})
                        begin
                            stats_next.count = stats_reg.count + 1'b1;
                            stats_next.sum   = sum_wide[smmat_pkg::SUM_BITS]
                                             ? {smmat_pkg::SUM_BITS{1'b1}}
                                             : sum_wide[smmat_pkg::SUM_BITS-1:0];
                        end
                    end
                end
                smmat_pkg::MODE_HOLD:   stats_next.hold = 1'b1;
                smmat_pkg::MODE_RESUME: stats_next.hold = 1'b0;
                smmat_pkg::MODE_CLEAR:
                begin
                    stats_next.latest    = '0;
                    stats_next.min_value = smmat_pkg::MIN_EMPTY;
                    stats_next.max_value = '0;
                    stats_next.sum       = '0;
                    stats_next.count     = '0;
                end
                default: stats_next = stats_reg;
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg.latest    <= '0;
            stats_reg.min_value <= smmat_pkg::MIN_EMPTY;
            stats_reg.max_value <= '0;
            stats_reg.sum       <= '0;
            stats_reg.count     <= '0;
            stats_reg.hold      <= 1'b0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

### design/smmat_divider.sv
// ----------------------------------------------------------------------------
// smmat_divider: bit-serial restoring divider
// One quotient bit per cycle; quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module smmat_divider #(
    parameter int DIVIDEND_BITS = smmat_pkg::SUM_BITS,
    parameter int DIVISOR_BITS  = smmat_pkg::COUNT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DIVIDEND_BITS-1:0]   dividend,
    input  logic [DIVISOR_BITS-1:0]    divisor,
    output logic [DIVIDEND_BITS-1:0]   quotient,
    output smmat_pkg::div_status_t     status
);

    localparam int STEP_W = $clog2(DIVIDEND_BITS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_BITS - 1);

    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  den_reg, den_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    // One shift-compare-subtract step
    always_comb
    begin
        logic [DIVISOR_BITS:0] trial;
        logic [DIVISOR_BITS:0] diff;
        trial     = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/sample_min_max_average_tracker_unit.sv
// ----------------------------------------------------------------------------
// sample_min_max_average_tracker_unit: running min / max / mean tracker
// Takes converter samples and hold / resume / clear commands, one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries a mode and a sample.
//   Mode sample updates last sample, min, max, count and sum unless holding;
//   hold and resume set and clear the hold flag; clear resets the statistics
//   but keeps the hold flag. Count and sum saturate and then stay put.
//   Output channel (out_valid / out_ready / out_data) returns one beat per
//   input beat: last sample, min, max, truncated sum / count (0 for an empty
//   count), count and hold flag, all after the beat is applied.
//   After input acceptance the statistics update on the accepting edge, the
//   sequencer launches the divider, the bit-serial divider produces one
//   quotient bit per cycle over the 32-bit sum, the sequencer sees it
//   finish and the output register is loaded, raising out_valid.
//   in_ready is high only while the sequencer is idle, so no new beat is
//   accepted until the previous result is loaded into the output register.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register empties, and in_ready stays low meanwhile.
//   Reset: min 1000, everything else zero, hold off, no output pending.
// ----------------------------------------------------------------------------
module sample_min_max_average_tracker_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smmat_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output smmat_pkg::out_beat_t out_data
);

    smmat_pkg::state_t      state_reg, state_next;
    smmat_pkg::stats_t      stats;
    smmat_pkg::div_status_t div_status;
    smmat_pkg::out_beat_t   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   in_accept;
    logic                   div_start;
    logic                   out_load;
    logic [smmat_pkg::SUM_BITS-1:0] quotient;

    assign in_accept = in_valid && in_ready;

    // Statistics registers
    smmat_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (in_accept),
        .beat   (in_data),
        .stats  (stats)
    );

    // Divider for the average
    smmat_divider #(
        .DIVIDEND_BITS (smmat_pkg::SUM_BITS),
        .DIVISOR_BITS  (smmat_pkg::COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stats.sum),
        .divisor  (stats.count),
        .quotient (quotient),
        .status   (div_status)
    );

    // Sequencer: next state and control
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            smmat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = smmat_pkg::ST_LAUNCH;
            end
            smmat_pkg::ST_LAUNCH:
            begin
                div_start  = 1'b1;
                state_next = smmat_pkg::ST_DIVIDE;
            end
            smmat_pkg::ST_DIVIDE:
            begin
                if (div_status.done)
                    state_next = smmat_pkg::ST_FINISH;
            end
            smmat_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = smmat_pkg::ST_IDLE;
                end
            end
            default: state_next = smmat_pkg::ST_IDLE;
        endcase
    end

    // Result assembly and output register control
    always_comb
    begin
        out_next = out_reg;
        if (out_load)
        begin
            out_next.last_sample  = stats.latest;
            out_next.minimum      = stats.min_value;
            out_next.maximum      = stats.max_value;
            out_next.average      = (stats.count == '0) ? '0
                                  : quotient[smmat_pkg::SAMPLE_BITS-1:0];
            out_next.sample_count = stats.count;
            out_next.holding      = stats.hold;
        end
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smmat_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Accepted beat always moves on to launch the divider
    a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == smmat_pkg::ST_LAUNCH)
        else $error("accepted beat did not launch the divider");

    // No new beat while the divider is running
    a_ready_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy)
        else $error("input ready while divider busy");

    // A fresh result only comes from the finish state
    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == smmat_pkg::ST_FINISH)
        else $error("output raised outside finish state");

    // Empty count reports a zero average
    a_empty_average: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.sample_count != '0 || out_reg.average == '0))
        else $error("non-zero average with zero count");

endmodule

### dv/smmat_stats_checker.sv
// ----------------------------------------------------------------------------
// smmat_stats_checker: beat monitor and scoreboard for the statistics tracker
// Watches both channels, keeps its own running min / max / sum / count / hold
// state, predicts the result for each input beat and compares result beats in
// order, field by field. Hands the error tally and the number of results still
// owed back to the testbench top.
// ----------------------------------------------------------------------------
module smmat_stats_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  smmat_pkg::in_beat_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  smmat_pkg::out_beat_t out_data,
    output int                   fail_count,
    output int                   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tracked statistics
    logic [smmat_pkg::SAMPLE_BITS-1:0] trk_latest;
    logic [smmat_pkg::SAMPLE_BITS-1:0] trk_min;
    logic [smmat_pkg::SAMPLE_BITS-1:0] trk_max;
    logic [smmat_pkg::SUM_BITS-1:0]    trk_sum;
    logic [smmat_pkg::COUNT_BITS-1:0]  trk_count;
    logic                              trk_hold;

    // Results owed by the block, oldest first
    smmat_pkg::out_beat_t stats_due_q[$];
    int                   errs;

    // Clear leaves the hold flag alone
    function automatic void clear_running_stats();
        trk_latest = '0;
        trk_min    = smmat_pkg::MIN_EMPTY;
        trk_max    = '0;
        trk_sum    = '0;
        trk_count  = '0;
    endfunction

    // Apply one input beat and return the statistics reported after it
    function automatic smmat_pkg::out_beat_t apply_beat(smmat_pkg::in_beat_t b);
        logic [smmat_pkg::SUM_BITS:0]   wide_sum;
        logic [smmat_pkg::SUM_BITS-1:0] quot;
        smmat_pkg::out_beat_t           r;
        case (b.mode)
            smmat_pkg::MODE_SAMPLE:
            begin
                if (!trk_hold)
                begin
                    trk_latest = b.sample;
                    if (b.sample < trk_min)
                        trk_min = b.sample;
                    if (b.sample > trk_max)
                        trk_max = b.sample;
                    // once the count is full, count and sum both stand still
                    if (trk_count != '1)
                    begin
                        wide_sum  = {1'b0, trk_sum}
                                  + (smmat_pkg::SUM_BITS + 1)'(b.sample);
                        trk_sum   = wide_sum[smmat_pkg::SUM_BITS]
                                  ? '1 : wide_sum[smmat_pkg::SUM_BITS-1:0];
                        trk_count = trk_count + 1'b1;
                    end
                end
            end
            smmat_pkg::MODE_HOLD:   trk_hold = 1'b1;
            smmat_pkg::MODE_RESUME: trk_hold = 1'b0;
            default:                clear_running_stats();
        endcase
        quot = (trk_count == '0) ? '0 : trk_sum / trk_count;
        r.last_sample  = trk_latest;
        r.minimum      = trk_min;
        r.maximum      = trk_max;
        r.average      = quot[smmat_pkg::SAMPLE_BITS-1:0];
        r.sample_count = trk_count;
        r.holding      = trk_hold;
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errs++;
        end
    endfunction

    // Result beats are checked before the input beat of the same edge is applied
    always @(posedge clk or negedge rst_n)
    begin
        smmat_pkg::out_beat_t want;
        if (!rst_n)
        begin
            clear_running_stats();
            trk_hold = 1'b0;
            stats_due_q.delete();
            errs = 0;
            fail_count  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (stats_due_q.size() == 0)
                begin
                    $error("result beat with no input beat outstanding");
                    errs++;
                end
                else
                begin
                    want = stats_due_q.pop_front();
                    check_field("last_sample", 32'(want.last_sample),
                                32'(out_data.last_sample));
                    check_field("minimum", 32'(want.minimum),
                                32'(out_data.minimum));
                    check_field("maximum", 32'(want.maximum),
                                32'(out_data.maximum));
                    check_field("average", 32'(want.average),
                                32'(out_data.average));
                    check_field("sample_count", 32'(want.sample_count),
                                32'(out_data.sample_count));
                    check_field("holding", 32'(want.holding),
                                32'(out_data.holding));
                end
            end
            if (in_valid && in_ready)
                stats_due_q.push_back(apply_beat(in_data));
            fail_count  <= errs;
            results_due <= stats_due_q.size();
        end
    end

endmodule

### dv/sample_min_max_average_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// sample_min_max_average_tracker_unit_tb: top-level bench for the tracker
// Drives directed corner beats and then random sample / command traffic in
// four flow-control phases, leaves checking to the scoreboard beside the
// block, and reports the verdict once every result has drained.
// ----------------------------------------------------------------------------
module sample_min_max_average_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BEATS = 900;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    smmat_pkg::in_beat_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    smmat_pkg::out_beat_t out_data;

    int fail_count;
    int results_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    sample_min_max_average_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    smmat_stats_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic smmat_pkg::in_beat_t beat(smmat_pkg::mode_t m,
                                                 logic [smmat_pkg::SAMPLE_BITS-1:0] s);
        smmat_pkg::in_beat_t b;
        b.mode   = m;
        b.sample = s;
        return b;
    endfunction

    // Mostly samples; resume outweighs hold so hold spells stay short
    function automatic smmat_pkg::in_beat_t random_beat();
        int                                pick;
        smmat_pkg::mode_t                  m;
        logic [smmat_pkg::SAMPLE_BITS-1:0] s;
        pick = $urandom_range(99);
        if (pick < 74)
            m = smmat_pkg::MODE_SAMPLE;
        else if (pick < 81)
            m = smmat_pkg::MODE_HOLD;
        else if (pick < 95)
            m = smmat_pkg::MODE_RESUME;
        else
            m = smmat_pkg::MODE_CLEAR;
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = '1;
            2:       s = (smmat_pkg::SAMPLE_BITS)'($urandom_range(
                             smmat_pkg::MIN_EMPTY_RAW + 1, smmat_pkg::MIN_EMPTY_RAW - 1));
            default: s = (smmat_pkg::SAMPLE_BITS)'($urandom());
        endcase
        return beat(m, s);
    endfunction

    // Present one beat and hold it until accepted; valid only drops for a gap
    task automatic send_beat(smmat_pkg::in_beat_t b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        smmat_pkg::in_beat_t b;
        int                  sent;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        send_beat(beat(smmat_pkg::MODE_RESUME, '1));            // resume while running
        send_beat(beat(smmat_pkg::MODE_SAMPLE, '0));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, '1));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd1000));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd999));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd1001));
        send_beat(beat(smmat_pkg::MODE_HOLD, 10'h155));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd5));         // ignored while held
        send_beat(beat(smmat_pkg::MODE_HOLD, 10'h2AA));         // hold again
        send_beat(beat(smmat_pkg::MODE_CLEAR, 10'h3FF));        // clear keeps hold
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd7));         // still ignored, empty stats
        send_beat(beat(smmat_pkg::MODE_RESUME, '0));
        send_beat(beat(smmat_pkg::MODE_RESUME, 10'h155));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, '1));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd1022));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd1));         // new minimum, exact average
        send_beat(beat(smmat_pkg::MODE_CLEAR, 10'h2AA));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'd1001));      // above the empty minimum
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'h2AA));
        send_beat(beat(smmat_pkg::MODE_SAMPLE, 10'h155));
        send_beat(beat(smmat_pkg::MODE_CLEAR, '0));

        // Random traffic over four flow-control phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            sent = 0;
            while (sent < RANDOM_BEATS / 4)
            begin
                b = random_beat();
                send_beat(b);
                sent++;
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
design/smmat_pkg.sv
design/smmat_stats.sv
design/smmat_divider.sv
design/sample_min_max_average_tracker_unit.sv
dv/smmat_stats_checker.sv
dv/sample_min_max_average_tracker_unit_tb.sv
